// ===== rtl/pts_pkg.sv =====
// shared types, codes and defaults of the periodic task scheduler
`default_nettype none
package pts_pkg;

  // default table depth
  localparam int unsigned MAX_TASKS_DEF = 16;
  // firings per dispatch
  localparam int unsigned RESULT_LIMIT = 16;
  // tick length after reset
  localparam logic [15:0] TICK_RESET = 16'd10;

  // operation codes
  localparam logic [1:0] FUNC_ADD      = 2'd0;
  localparam logic [1:0] FUNC_DELETE   = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;
  localparam logic [1:0] FUNC_DISPATCH = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  // one table slot as stored in memory
  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] countdown;
    logic [31:0] period;
    logic [7:0]  pending;
  } entry_t;

  // one result item
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] idx;
    logic [7:0] handle;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/pts_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module pts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] waddr_i,
  input  wire  [Width-1:0]         wdata_i,
  input  wire  [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/pts_div.sv =====
// radix-2 restoring divider, 32 by 16 bits, one quotient bit per cycle
`default_nettype none
module pts_div (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [31:0] dividend_i,
  input  wire  [15:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [31:0] quot_q;
  logic [15:0] rem_q;
  logic [15:0] dvs_q;
  logic        done_q;
  logic [16:0] trial;
  logic [16:0] diff;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quot_q[31]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      quot_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd31);
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
        quot_q <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        if (!diff[16]) begin
          rem_q  <= diff[15:0];
          quot_q <= {quot_q[30:0], 1'b1};
        end else begin
          rem_q  <= trial[15:0];
          quot_q <= {quot_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ===== rtl/periodic_task_scheduler_unit.sv =====
// top level: slot table in memory, sequencer for add, delete, tick and dispatch
// add runs two divisions; delete shifts each later slot down, tick visits each occupied slot,
// dispatch examines slots in order and shifts out the one-shot slots that fire
// one command at a time; the divider and the read-modify-write of the slot memory set the pace
// reset clears the slot count, so no clearing pass of the memory is needed;
// the tick length returns to 10 and the output register empties
`default_nettype none
module periodic_task_scheduler_unit #(
  parameter int unsigned MaxTasks = pts_pkg::MAX_TASKS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [79:0] s_axis_tdata,  // delay_ms, period_ms, task_handle, slot, zero pad
  input  wire  [1:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,  // slot_index, fired_handle, zero pad
  output logic [1:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast
);

  localparam int unsigned IW = $clog2(MaxTasks);
  localparam int unsigned CW = $clog2(MaxTasks + 1);
  localparam int unsigned XW = (CW > 4) ? CW : 4;
  localparam int unsigned EW = $bits(pts_pkg::entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVA, S_DIVA_W, S_DIVB, S_DIVB_W, S_SRD, S_SWR,
    S_TRD, S_TMOD, S_DRD, S_DMOD, S_DPUSH, S_EMIT
  } state_e;

  state_e          state_q;
  logic [15:0]     tick_q;
  logic [1:0]      func_q;
  logic [31:0]     delay_q;
  logic [31:0]     period_q;
  logic [7:0]      handle_q;
  logic [3:0]      slot_q;
  logic [31:0]     qdly_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   idx_q;
  logic [CW-1:0]   sh_q;
  logic [4:0]      n_q;
  logic            ret_disp_q;
  logic            per0_q;
  pts_pkg::res_t   res_q;
  pts_pkg::res_t   hold_q;
  logic            hold_v_q;
  pts_pkg::res_t   new_q;
  pts_pkg::res_t   out_q;
  logic            out_v_q;
  logic            out_last_q;

  logic            can_emit;
  logic            out_load;
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  pts_pkg::entry_t ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;
  pts_pkg::entry_t rd_e;
  pts_pkg::entry_t tick_e;
  logic            div_start;
  logic [31:0]     div_dividend;
  logic [15:0]     div_divisor;
  logic            div_busy;
  logic            div_done;
  logic [31:0]     div_quot;
  logic [CW-1:0]   sh_next;

  assign can_emit = !out_v_q || m_axis_tready;
  assign rd_e     = pts_pkg::entry_t'(ram_rdata);
  assign sh_next  = sh_q + CW'(1);

  // output register takes a new result this cycle
  assign out_load = can_emit &&
                    ((state_q == S_EMIT) || (state_q == S_DPUSH && hold_v_q));

  // tick update of one slot
  always_comb begin
    tick_e = rd_e;
    if (rd_e.countdown != 32'd0) begin
      tick_e.countdown = rd_e.countdown - 32'd1;
    end else begin
      tick_e.countdown = rd_e.period;
      if (rd_e.pending != 8'hff) begin
        tick_e.pending = rd_e.pending + 8'd1;
      end
    end
  end

  // memory and divider controls per state
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = idx_q[IW-1:0];
    ram_wdata    = rd_e;
    ram_raddr    = idx_q[IW-1:0];
    div_start    = 1'b0;
    div_dividend = delay_q;
    unique case (state_q)
      S_DIVA: div_start = 1'b1;
      S_DIVB: begin
        div_start    = 1'b1;
        div_dividend = period_q;
      end
      S_DIVB_W: begin
        ram_we    = div_done;
        ram_waddr = cnt_q[IW-1:0];
        ram_wdata = '{handle: handle_q, countdown: qdly_q, period: div_quot, pending: 8'd0};
      end
      S_SRD: ram_raddr = sh_next[IW-1:0];
      S_SWR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_q[IW-1:0];
      end
      S_TMOD: begin
        ram_we    = 1'b1;
        ram_wdata = tick_e;
      end
      S_DMOD: begin
        ram_we            = (rd_e.pending != 8'd0);
        ram_wdata.pending = rd_e.pending - 8'd1;
      end
      default: ;
    endcase
  end

  assign div_divisor = (tick_q == 16'd0) ? 16'd1 : tick_q;

  pts_ram #(.Width(EW), .Depth(MaxTasks)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sequencer, slot count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tick_q     <= pts_pkg::TICK_RESET;
      cnt_q      <= '0;
      out_v_q    <= 1'b0;
      hold_v_q   <= 1'b0;
      idx_q      <= '0;
      sh_q       <= '0;
      n_q        <= '0;
      ret_disp_q <= 1'b0;
      func_q     <= '0;
      delay_q    <= '0;
      period_q   <= '0;
      handle_q   <= '0;
      slot_q     <= '0;
      qdly_q     <= '0;
      per0_q     <= 1'b0;
      res_q      <= '0;
      hold_q     <= '0;
      new_q      <= '0;
      out_q      <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tick_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func_q   <= s_axis_tuser;
            delay_q  <= s_axis_tdata[31:0];
            period_q <= s_axis_tdata[63:32];
            handle_q <= s_axis_tdata[71:64];
            slot_q   <= s_axis_tdata[75:72];
            idx_q    <= '0;
            n_q      <= '0;
            hold_v_q <= 1'b0;
            unique case (s_axis_tuser)
              pts_pkg::FUNC_ADD: begin
                if (cnt_q < CW'(MaxTasks)) begin
                  state_q <= S_DIVA;
                end else begin
                  res_q   <= '{status: pts_pkg::ST_FULL, idx: 4'd0, handle: 8'd0};
                  state_q <= S_EMIT;
                end
              end
              pts_pkg::FUNC_DELETE: begin
                if (XW'(s_axis_tdata[75:72]) < XW'(cnt_q)) begin
                  sh_q       <= CW'(s_axis_tdata[75:72]);
                  ret_disp_q <= 1'b0;
                  state_q    <= S_SRD;
                end else begin
                  res_q   <= '{status: pts_pkg::ST_BAD, idx: s_axis_tdata[75:72],
                               handle: 8'd0};
                  state_q <= S_EMIT;
                end
              end
              pts_pkg::FUNC_TICK:     state_q <= S_TRD;
              pts_pkg::FUNC_DISPATCH: state_q <= S_DRD;
              default:                state_q <= S_IDLE;
            endcase
          end
        end
        S_DIVA:   state_q <= S_DIVA_W;
        S_DIVA_W: begin
          if (div_done) begin
            qdly_q  <= div_quot;
            state_q <= S_DIVB;
          end
        end
        S_DIVB:   state_q <= S_DIVB_W;
        S_DIVB_W: begin
          if (div_done) begin
            cnt_q   <= cnt_q + CW'(1);
            res_q   <= '{status: pts_pkg::ST_OK, idx: 4'(cnt_q), handle: 8'd0};
            state_q <= S_EMIT;
          end
        end
        // shift later slots down by one
        S_SRD: begin
          if (sh_next < cnt_q) begin
            state_q <= S_SWR;
          end else begin
            cnt_q <= cnt_q - CW'(1);
            if (ret_disp_q) begin
              state_q <= S_DRD;
            end else begin
              res_q   <= '{status: pts_pkg::ST_OK, idx: slot_q, handle: 8'd0};
              state_q <= S_EMIT;
            end
          end
        end
        S_SWR: begin
          sh_q    <= sh_next;
          state_q <= S_SRD;
        end
        // tick walk
        S_TRD: begin
          if (idx_q < cnt_q) begin
            state_q <= S_TMOD;
          end else begin
            res_q   <= '{status: pts_pkg::ST_OK, idx: 4'd0, handle: 8'd0};
            state_q <= S_EMIT;
          end
        end
        S_TMOD: begin
          idx_q   <= idx_q + CW'(1);
          state_q <= S_TRD;
        end
        // dispatch walk, last firing held back until its successor is known
        S_DRD: begin
          if (idx_q < cnt_q && n_q < 5'(pts_pkg::RESULT_LIMIT)) begin
            state_q <= S_DMOD;
          end else begin
            res_q    <= hold_v_q ? hold_q
                      : pts_pkg::res_t'{status: pts_pkg::ST_NONE, idx: 4'd0, handle: 8'd0};
            hold_v_q <= 1'b0;
            state_q  <= S_EMIT;
          end
        end
        S_DMOD: begin
          if (rd_e.pending != 8'd0) begin
            new_q   <= '{status: pts_pkg::ST_OK, idx: 4'(idx_q), handle: rd_e.handle};
            per0_q  <= (rd_e.period == 32'd0);
            state_q <= S_DPUSH;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_DRD;
          end
        end
        S_DPUSH: begin
          if (!hold_v_q || can_emit) begin
            if (hold_v_q) begin
              out_q      <= hold_q;
              out_last_q <= 1'b0;
            end
            hold_q   <= new_q;
            hold_v_q <= 1'b1;
            n_q      <= n_q + 5'd1;
            if (per0_q) begin
              sh_q       <= idx_q;
              ret_disp_q <= 1'b1;
              state_q    <= S_SRD;
            end else begin
              idx_q   <= idx_q + CW'(1);
              state_q <= S_DRD;
            end
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            out_q      <= res_q;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'd0, out_q.handle, out_q.idx};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_last_q;

  // slot count never exceeds the table depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxTasks)) else $error("slot count beyond table depth");

  // divider is idle whenever a new item can be taken
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy) else $error("divider busy while idle");

  // a nothing-ready result carries no handle and ends its run
  a_none_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == pts_pkg::ST_NONE) |->
      (m_axis_tlast && m_axis_tdata == 16'd0)) else $error("bad nothing-ready result");

  // a held firing is only pending while a dispatch is in progress
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q |-> (func_q == pts_pkg::FUNC_DISPATCH && state_q != S_IDLE))
    else $error("held firing outside dispatch");

endmodule
`default_nettype wire

// ===== tb/periodic_task_scheduler_checker.sv =====
// checker for the periodic task scheduler: predicts each result and compares transfers
`timescale 1ns / 1ps
module periodic_task_scheduler_checker #(
  parameter int unsigned MaxTasks = pts_pkg::MAX_TASKS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [79:0] s_axis_tdata,
  input  wire  [1:0]  s_axis_tuser,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [15:0] m_axis_tdata,
  input  wire  [1:0]  m_axis_tuser,
  input  wire         m_axis_tlast,
  output int unsigned failures_o,
  output int unsigned outstanding_o
);

  typedef struct {
    logic [1:0] status;
    logic [3:0] idx;
    logic [7:0] handle;
    logic       last;
  } firing_t;

  firing_t     firings_due[$];
  logic [7:0]  task_handle[MaxTasks];
  logic [31:0] task_countdown[MaxTasks];
  logic [31:0] task_period[MaxTasks];
  logic [7:0]  task_pending[MaxTasks];
  int unsigned slots_used;
  logic [15:0] tick_ms;

  function automatic void clear_table();
    for (int i = 0; i < MaxTasks; i++) begin
      task_handle[i] = '0;
      task_countdown[i] = '0;
      task_period[i] = '0;
      task_pending[i] = '0;
    end
    slots_used = 0;
  endfunction

  // remove a slot and close the gap
  function automatic void drop_slot(int unsigned s);
    if (s >= slots_used) return;
    for (int unsigned i = s; i + 1 < slots_used; i++) begin
      task_handle[i] = task_handle[i+1];
      task_countdown[i] = task_countdown[i+1];
      task_period[i] = task_period[i+1];
      task_pending[i] = task_pending[i+1];
    end
    slots_used--;
    task_handle[slots_used] = '0;
    task_countdown[slots_used] = '0;
    task_period[slots_used] = '0;
    task_pending[slots_used] = '0;
  endfunction

  function automatic void owe(logic [1:0] st, int unsigned idx, logic [7:0] h);
    firings_due.push_back('{st, idx[3:0], h, 1'b0});
  endfunction

  // work out the results of one command and update the table copy
  function automatic void schedule_command(logic [1:0] func, logic [31:0] delay_ms,
                                           logic [31:0] period_ms, logic [7:0] h,
                                           logic [3:0] s);
    logic [31:0] div;
    int unsigned fired;
    int unsigned i;
    div = (tick_ms == 0) ? 32'd1 : {16'd0, tick_ms};
    fired = 0;
    case (func)
      pts_pkg::FUNC_ADD: begin
        if (slots_used < MaxTasks) begin
          task_handle[slots_used] = h;
          task_countdown[slots_used] = delay_ms / div;
          task_period[slots_used] = period_ms / div;
          task_pending[slots_used] = '0;
          owe(pts_pkg::ST_OK, slots_used, 8'd0);
          slots_used++;
        end else begin
          owe(pts_pkg::ST_FULL, 0, 8'd0);
        end
      end
      pts_pkg::FUNC_DELETE: begin
        if (s >= slots_used) begin
          owe(pts_pkg::ST_BAD, s, 8'd0);
        end else begin
          drop_slot(s);
          owe(pts_pkg::ST_OK, s, 8'd0);
        end
      end
      pts_pkg::FUNC_TICK: begin
        for (i = 0; i < slots_used; i++) begin
          if (task_countdown[i] != 0) begin
            task_countdown[i]--;
          end else begin
            task_countdown[i] = task_period[i];
            if (task_pending[i] != 8'hFF) task_pending[i]++;
          end
        end
        owe(pts_pkg::ST_OK, 0, 8'd0);
      end
      default: begin
        i = 0;
        while (i < slots_used && fired < pts_pkg::RESULT_LIMIT) begin
          if (task_pending[i] != 0) begin
            task_pending[i]--;
            owe(pts_pkg::ST_OK, i, task_handle[i]);
            fired++;
            if (task_period[i] == 0) begin
              drop_slot(i);
              continue;
            end
          end
          i++;
        end
        if (fired == 0) owe(pts_pkg::ST_NONE, 0, 8'd0);
      end
    endcase
    firings_due[firings_due.size()-1].last = 1'b1;
  endfunction

  // compare result transfers, then predict command transfers
  always @(posedge clk_i or negedge rst_ni) begin
    firing_t want;
    if (!rst_ni) begin
      clear_table();
      firings_due.delete();
      tick_ms = pts_pkg::TICK_RESET;
      failures_o = 0;
      outstanding_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (firings_due.size() == 0) begin
          $error("result transfer with nothing expected");
          failures_o++;
        end else begin
          want = firings_due.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            failures_o++;
          end
          if (m_axis_tdata[3:0] !== want.idx) begin
            $error("slot_index: expected %0d, got %0d", want.idx, m_axis_tdata[3:0]);
            failures_o++;
          end
          if (m_axis_tdata[11:4] !== want.handle) begin
            $error("fired_handle: expected %0d, got %0d", want.handle,
                   m_axis_tdata[11:4]);
            failures_o++;
          end
          if (m_axis_tdata[15:12] !== 4'd0) begin
            $error("tdata pad: expected 0, got %0h", m_axis_tdata[15:12]);
            failures_o++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
            failures_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        schedule_command(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                         s_axis_tdata[71:64], s_axis_tdata[75:72]);
      if (cfg_we_i) tick_ms = cfg_wdata_i;
      outstanding_o = firings_due.size();
    end
  end

endmodule

// ===== tb/periodic_task_scheduler_unit_test.sv =====
// testbench top: stimulus, flow control and verdict for the periodic task scheduler
`timescale 1ns / 1ps
module periodic_task_scheduler_unit_test;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // delay_ms, period_ms, task_handle, slot, zero pad
  logic [1:0]  s_axis_tuser = '0;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // slot_index, fired_handle, zero pad
  logic [1:0]  m_axis_tuser;        // status
  logic        m_axis_tlast;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned tx_idle_pct = 25;
  int unsigned rx_idle_pct = 54;
  bit          hold_off_req = 1'b0;
  logic [15:0] cur_tick = pts_pkg::TICK_RESET;

  periodic_task_scheduler_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  periodic_task_scheduler_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .failures_o(failures), .outstanding_o(outstanding)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("periodic_task_scheduler_unit_test NOT OK");
    $finish;
  end

  // result side: random back-pressure, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // offer one command and wait for its transfer
  task automatic send_cmd(logic [1:0] func, logic [31:0] delay_ms, logic [31:0] period_ms,
                          logic [7:0] h, logic [3:0] s);
    bit taken;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'd0, s, h, period_ms, delay_ms};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // stop offering, wait for every result, let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_tick(logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    cur_tick = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one random command, add share in percent
  task automatic random_cmd(int unsigned add_pct);
    int unsigned pick;
    logic [31:0] scale;
    logic [31:0] dly;
    logic [31:0] per;
    pick = $urandom_range(99);
    scale = (cur_tick == 0) ? 32'd1 : {16'd0, cur_tick};
    dly = ($urandom_range(3) == 0) ? $urandom : scale * $urandom_range(4);
    per = ($urandom_range(3) == 0) ? $urandom
        : ($urandom_range(2) == 0) ? 32'd0 : scale * $urandom_range(3);
    if (pick < add_pct)
      send_cmd(pts_pkg::FUNC_ADD, dly, per, 8'($urandom_range(255)),
               4'($urandom_range(15)));
    else if (pick < add_pct + 12)
      send_cmd(pts_pkg::FUNC_DELETE, $urandom, $urandom, 8'($urandom_range(255)),
               4'($urandom_range(15)));
    else if (pick < add_pct + 12 + (100 - add_pct - 12) / 2)
      send_cmd(pts_pkg::FUNC_TICK, $urandom, $urandom, 8'($urandom_range(255)),
               4'($urandom_range(15)));
    else
      send_cmd(pts_pkg::FUNC_DISPATCH, $urandom, $urandom, 8'($urandom_range(255)),
               4'($urandom_range(15)));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: empty table, extremes of the fields, one-shot removal
    set_tick(16'd1);
    send_cmd(pts_pkg::FUNC_DISPATCH, '0, '0, '0, '0);
    send_cmd(pts_pkg::FUNC_DELETE, '0, '0, '0, 4'd0);
    send_cmd(pts_pkg::FUNC_TICK, '0, '0, '0, '0);
    send_cmd(pts_pkg::FUNC_ADD, 32'd0, 32'd0, 8'hA5, 4'd0);
    send_cmd(pts_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF);
    send_cmd(pts_pkg::FUNC_ADD, 32'd0, 32'd2, 8'h00, 4'd0);
    send_cmd(pts_pkg::FUNC_ADD, 32'd0, 32'd0, 8'h5A, 4'd0);
    send_cmd(pts_pkg::FUNC_TICK, '0, '0, '0, '0);
    send_cmd(pts_pkg::FUNC_TICK, '0, '0, '0, '0);
    send_cmd(pts_pkg::FUNC_DISPATCH, '0, '0, '0, '0);
    send_cmd(pts_pkg::FUNC_DISPATCH, '0, '0, '0, '0);
    send_cmd(pts_pkg::FUNC_DELETE, '0, '0, '0, 4'd15);
    send_cmd(pts_pkg::FUNC_DELETE, '0, '0, '0, 4'd1);
    send_cmd(pts_pkg::FUNC_ADD, 32'd7, 32'd9, 8'h3C, 4'd0);
    send_cmd(pts_pkg::FUNC_DISPATCH, '0, '0, '0, '0);
    drain();

    // phase one: long tick, table fills up, long result hold-off
    set_tick(16'd65535);
    for (int n = 0; n < 18; n++)
      send_cmd(pts_pkg::FUNC_ADD, $urandom, $urandom, 8'($urandom), 4'($urandom));
    hold_off_req = 1'b1;
    for (int n = 0; n < 20; n++) random_cmd(40);
    drain();

    // phase two: swapped idling, shortest tick, many firings
    tx_idle_pct = 54;
    rx_idle_pct = 25;
    set_tick(16'd1);
    for (int n = 0; n < 20; n++) random_cmd(30);
    drain();

    // phase three: no idling, zero tick length, pending counts saturate
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_tick(16'd0);
    send_cmd(pts_pkg::FUNC_ADD, 32'd0, 32'd0, 8'h81, 4'd0);
    for (int n = 0; n < 258; n++) send_cmd(pts_pkg::FUNC_TICK, '0, '0, '0, '0);
    for (int n = 0; n < 2; n++) send_cmd(pts_pkg::FUNC_DISPATCH, '0, '0, '0, '0);
    drain();
    set_tick(16'd7);
    for (int n = 0; n < 10; n++) random_cmd(30);

    // wind down
    drain();
    if (failures == 0) begin
      $display("periodic_task_scheduler_unit_test OK");
    end else begin
      $display("periodic_task_scheduler_unit_test NOT OK");
    end
    $finish;
  end

endmodule
